// File: rtl/cdq_pkg.sv
// Shared types and codes for the circular double-ended queue.
package cdq_pkg;

	localparam int DATA_BITS = 32;
	localparam int FILL_BITS = 7;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_REAR  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_REAR   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef logic signed [DATA_BITS-1:0] data_t;
	typedef logic [FILL_BITS-1:0]        fill_t;

endpackage

// File: rtl/cdq_if.sv
// Request and response channel interfaces of the deque.
interface cdq_req_if;
	import cdq_pkg::*;
	logic  valid;
	logic  ready;
	act_t  action;
	data_t value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface cdq_rsp_if;
	import cdq_pkg::*;
	logic    valid;
	logic    ready;
	status_t status;
	data_t   popped_value;
	data_t   front_value;
	data_t   rear_value;
	logic    ends_valid;
	fill_t   fill_count;

	modport source (output valid, output status, output popped_value, output front_value,
		output rear_value, output ends_valid, output fill_count, input ready);
	modport sink (input valid, input status, input popped_value, input front_value,
		input rear_value, input ends_valid, input fill_count, output ready);
endinterface

// File: rtl/cdq_ram.sv
// Word store: one write port, one read port with registered read data.
module cdq_ram #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WORD_BITS-1:0]     wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WORD_BITS-1:0]     rd_data
);
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/circular_deque.sv
// Top level of the circular double-ended queue.
//
//  channel | dir | payload
//  req     | in  | action, value
//  rsp     | out | status, popped_value, front_value, rear_value, ends_valid, fill_count
//
// A push or a refused operation answers from S_IDLE; a pop that leaves two or more
// words passes through S_FILL too, waiting on the store read of the new end word.
// The front and rear words are held in registers beside the store.
// A result not yet taken stalls the input; a new word enters in the cycle it is taken.
// Reset clears indices and count; the store itself is not cleared.
module circular_deque #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	cdq_req_if.sink          req,
	cdq_rsp_if.source        rsp
);
	import cdq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	typedef enum logic {S_IDLE, S_FILL} state_t;

	state_t               state_q;
	logic [IW-1:0]        head_q;
	logic [IW-1:0]        tail_q;
	logic [CW-1:0]        held_q;
	logic [WORD_BITS-1:0] front_q;
	logic [WORD_BITS-1:0] rear_q;
	logic                 fill_front_q;
	logic                 rsp_valid_q;
	status_t              status_q;
	data_t                popped_q;
	data_t                front_out_q;
	data_t                rear_out_q;
	logic                 ends_valid_q;
	fill_t                fill_q;

	logic                 accept;
	logic [WORD_BITS-1:0] word;
	logic [IW-1:0]        head_n;
	logic [IW-1:0]        tail_n;
	logic [CW-1:0]        held_n;
	logic [WORD_BITS-1:0] front_n;
	logic [WORD_BITS-1:0] rear_n;
	status_t              status_n;
	data_t                popped_n;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic                 fill_front_n;
	logic [WORD_BITS-1:0] rd_data;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign word      = WORD_BITS'(req.value);

	always_comb begin
		head_n       = head_q;
		tail_n       = tail_q;
		held_n       = held_q;
		front_n      = front_q;
		rear_n       = rear_q;
		status_n     = ST_DONE;
		popped_n     = '0;
		wr_en        = 1'b0;
		wr_addr      = head_q;
		rd_en        = 1'b0;
		rd_addr      = head_q;
		fill_front_n = 1'b0;
		case (req.action)
			ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
				if (held_q == CW'(DEPTH)) begin
					status_n = ST_OVERFLOW;
				end else begin
					held_n = held_q + 1'b1;
					wr_en  = accept;
					if (held_q == '0) begin
						head_n  = '0;
						tail_n  = '0;
						front_n = word;
						rear_n  = word;
						wr_addr = '0;
					end else if (req.action == ACT_PUSH_FRONT) begin
						head_n  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
						front_n = word;
						wr_addr = head_n;
					end else begin
						tail_n  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
						rear_n  = word;
						wr_addr = tail_n;
					end
				end
			end
			ACT_POP_FRONT, ACT_POP_REAR: begin
				if (held_q == '0) begin
					status_n = ST_EMPTY;
				end else begin
					held_n = held_q - 1'b1;
					if (req.action == ACT_POP_FRONT) begin
						popped_n = DATA_BITS'(signed'(front_q));
						head_n   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
						front_n  = rear_q;
						rd_addr  = head_n;
						fill_front_n = 1'b1;
					end else begin
						popped_n = DATA_BITS'(signed'(rear_q));
						tail_n   = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
						rear_n   = front_q;
						rd_addr  = tail_n;
					end
					if (held_n == '0) begin
						head_n = '0;
						tail_n = '0;
					end
					rd_en = accept && (held_n > CW'(1));
				end
			end
			default: begin
				status_n = ST_DONE;
			end
		endcase
	end

	cdq_ram #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			held_q       <= '0;
			front_q      <= '0;
			rear_q       <= '0;
			rsp_valid_q  <= 1'b0;
			fill_front_q <= 1'b0;
			status_q     <= ST_DONE;
			popped_q     <= '0;
			front_out_q  <= '0;
			rear_out_q   <= '0;
			ends_valid_q <= 1'b0;
			fill_q       <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						head_q       <= head_n;
						tail_q       <= tail_n;
						held_q       <= held_n;
						front_q      <= front_n;
						rear_q       <= rear_n;
						fill_front_q <= fill_front_n;
						status_q     <= status_n;
						popped_q     <= popped_n;
						ends_valid_q <= (held_n != '0);
						fill_q       <= FILL_BITS'(held_n);
						front_out_q  <= (held_n != '0) ? DATA_BITS'(signed'(front_n)) : '0;
						rear_out_q   <= (held_n != '0) ? DATA_BITS'(signed'(rear_n)) : '0;
						if (rd_en) begin
							state_q <= S_FILL;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				S_FILL: begin
					if (fill_front_q) begin
						front_q     <= rd_data;
						front_out_q <= DATA_BITS'(signed'(rd_data));
					end else begin
						rear_q     <= rd_data;
						rear_out_q <= DATA_BITS'(signed'(rd_data));
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.popped_value = popped_q;
	assign rsp.front_value  = front_out_q;
	assign rsp.rear_value   = rear_out_q;
	assign rsp.ends_valid   = ends_valid_q;
	assign rsp.fill_count   = fill_q;

`ifndef SYNTH
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(DEPTH))
		else $error("held count above capacity");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == '0 |-> head_q == '0 && tail_q == '0)
		else $error("indices not at zero when empty");

	a_single_idx: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == CW'(1) |-> head_q == tail_q)
		else $error("head and tail differ with one word held");

	a_fill_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> $past(rd_en) && !rsp_valid_q)
		else $error("fill state without a store read");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> $stable(status_q) && $stable(fill_q))
		else $error("waiting result overwritten");
`endif

endmodule
